[hdl/orse_pkg.sv]
// Shared types and constants for the rank select engine.
package orse_pkg;

    localparam int EPOCH_W = 8;

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_SEL_CHK,
        ST_LO_ISS,
        ST_LO_CHK,
        ST_HI_ISS,
        ST_HI_CHK,
        ST_QS_TOP,
        ST_QS_PIV,
        ST_QS_JRD,
        ST_QS_JCMP,
        ST_RD_RES,
        ST_SW0,
        ST_SW1,
        ST_SW2,
        ST_SW3,
        ST_PRE0,
        ST_PRE1,
        ST_PRE_ISS,
        ST_PRE_CMP,
        ST_PRE_MARK,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        RET_INC,
        RET_PIV,
        RET_PRE1,
        RET_PRE2
    } ret_t;

endpackage

[hdl/online_rank_select_engine.sv]
// Rank select engine: element store with lazy quickselect under a sequencer.
// Load item: written in the idle state; a last load adds a min/max placement pass.
// Select item: read out directly when the slot is final, else a gap scan over unmarked
// slots, then partition passes of element compares and swaps (one memory read port).
// Synchronous active-low reset, then a mark clearing pass over all DEPTH slots without accepting items;
// the same pass repeats after every 255 loads when the mark epoch wraps.
module online_rank_select_engine #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic signed [31:0] s_value,
    input  logic               s_last,
    input  logic [10:0]        s_rank,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_selected,
    output logic               m_error
);
    import orse_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 11) ? CW : 11;
    localparam int DW   = DATA_WIDTH;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;
    logic [CW-1:0]      cnt_reg, cnt_next, k_reg, k_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic               pre_reg, pre_next;
    logic [AW-1:0]      i_reg, i_next, j_reg, j_next, l_reg, l_next, r_reg, r_next;
    logic [AW-1:0]      s_reg, s_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [AW-1:0]      swa_reg, swa_next, swb_reg, swb_next;
    logic [DW-1:0]      lov_reg, lov_next, hiv_reg, hiv_next, piv_reg, piv_next;
    logic [DW-1:0]      tmp_reg, tmp_next, res_reg, res_next;
    logic               err_reg, err_next;
    logic               mv_reg, mv_next, me_reg, me_next;
    logic [31:0]        ms_reg, ms_next;

    logic          d_we, m_we;
    logic [AW-1:0] d_waddr, d_raddr, m_waddr, m_raddr;
    logic [DW-1:0] d_wdata, d_rdata, fit_val;
    logic [EPOCH_W-1:0] m_wdata, m_rdata;
    logic [31:0]   res_out;
    logic          hit;
    logic [CMPW-1:0] rank_x, cnt_x, rank_m1;
    logic [CW-1:0]   cnt_m1;

    orse_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_data (
        .aclk(aclk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata)
    );

    orse_ram #(.WIDTH(EPOCH_W), .DEPTH(DEPTH)) u_mark (
        .aclk(aclk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    generate
        if (DW <= 32) begin : g_narrow
            assign fit_val = s_value[DW-1:0];
            assign res_out = {{(33-DW){res_reg[DW-1]}}, res_reg[DW-2:0]};
        end else begin : g_wide
            assign fit_val = {{(DW-32){s_value[31]}}, s_value};
            assign res_out = res_reg[31:0];
        end
    endgenerate

    assign hit     = (m_rdata == epoch_reg);
    assign rank_x  = CMPW'(s_rank);
    assign cnt_x   = CMPW'(cnt_reg);
    assign rank_m1 = rank_x - CMPW'(1);
    assign cnt_m1  = cnt_reg - CW'(1);

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = mv_reg;
    assign m_selected = ms_reg;
    assign m_error    = me_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            cnt_reg   <= '0;
            epoch_reg <= EPOCH_MAX;
            clr_reg   <= '0;
            pre_reg   <= 1'b0;
            mv_reg    <= 1'b0;
            ret_reg   <= RET_INC;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            epoch_reg <= epoch_next;
            clr_reg   <= clr_next;
            pre_reg   <= pre_next;
            mv_reg    <= mv_next;
            ret_reg   <= ret_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg   <= k_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        l_reg   <= l_next;
        r_reg   <= r_next;
        s_reg   <= s_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        swa_reg <= swa_next;
        swb_reg <= swb_next;
        lov_reg <= lov_next;
        hiv_reg <= hiv_next;
        piv_reg <= piv_next;
        tmp_reg <= tmp_next;
        res_reg <= res_next;
        err_reg <= err_next;
        ms_reg  <= ms_next;
        me_reg  <= me_next;
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        epoch_next = epoch_reg;
        clr_next   = clr_reg;
        pre_next   = pre_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        s_next     = s_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        swa_next   = swa_reg;
        swb_next   = swb_reg;
        lov_next   = lov_reg;
        hiv_next   = hiv_reg;
        piv_next   = piv_reg;
        tmp_next   = tmp_reg;
        res_next   = res_reg;
        err_next   = err_reg;
        mv_next    = mv_reg;
        ms_next    = ms_reg;
        me_next    = me_reg;
        d_we       = 1'b0;
        d_waddr    = swa_reg;
        d_wdata    = d_rdata;
        d_raddr    = s_reg;
        m_we       = 1'b0;
        m_waddr    = s_reg;
        m_wdata    = epoch_reg;
        m_raddr    = s_reg;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLR: begin
                m_we     = 1'b1;
                m_waddr  = clr_reg;
                m_wdata  = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    clr_next   = '0;
                    epoch_next = EPOCH_ONE;
                    pre_next   = 1'b0;
                    state_next = pre_reg ? ST_PRE0 : ST_IDLE;
                end
            end
            ST_IDLE: begin
                m_raddr = rank_m1[AW-1:0];
                if (s_valid) begin
                    if (!s_cmd) begin
                        if (cnt_reg < CW'(DEPTH)) begin
                            d_we     = 1'b1;
                            d_waddr  = cnt_reg[AW-1:0];
                            d_wdata  = fit_val;
                            cnt_next = cnt_reg + CW'(1);
                        end
                        if (epoch_reg == EPOCH_MAX) begin
                            pre_next   = s_last;
                            state_next = ST_CLR;
                        end else begin
                            epoch_next = epoch_reg + EPOCH_ONE;
                            state_next = s_last ? ST_PRE0 : ST_IDLE;
                        end
                    end else if (s_rank == 11'd0 || rank_x > cnt_x) begin
                        res_next   = '0;
                        err_next   = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        s_next     = rank_m1[AW-1:0];
                        state_next = ST_SEL_CHK;
                    end
                end
            end
            ST_SEL_CHK: begin
                if (hit) begin
                    state_next = ST_RD_RES;
                end else begin
                    l_next     = s_reg;
                    r_next     = s_reg;
                    state_next = ST_LO_ISS;
                end
            end
            ST_LO_ISS: begin
                m_raddr = l_reg - AW'(1);
                state_next = (l_reg == '0) ? ST_HI_ISS : ST_LO_CHK;
            end
            ST_LO_CHK: begin
                if (hit) begin
                    state_next = ST_HI_ISS;
                end else begin
                    l_next     = l_reg - AW'(1);
                    state_next = ST_LO_ISS;
                end
            end
            ST_HI_ISS: begin
                m_raddr = r_reg + AW'(1);
                if (CW'(r_reg) + CW'(1) >= cnt_reg) begin
                    state_next = ST_QS_TOP;
                end else begin
                    state_next = ST_HI_CHK;
                end
            end
            ST_HI_CHK: begin
                if (hit) begin
                    state_next = ST_QS_TOP;
                end else begin
                    r_next     = r_reg + AW'(1);
                    state_next = ST_HI_ISS;
                end
            end
            ST_QS_TOP: begin
                if (l_reg >= r_reg) begin
                    m_we       = 1'b1;
                    state_next = ST_RD_RES;
                end else begin
                    d_raddr    = r_reg;
                    state_next = ST_QS_PIV;
                end
            end
            ST_QS_PIV: begin
                piv_next   = d_rdata;
                i_next     = l_reg;
                j_next     = l_reg;
                state_next = ST_QS_JRD;
            end
            ST_QS_JRD: begin
                d_raddr = j_reg;
                if (j_reg < r_reg) begin
                    state_next = ST_QS_JCMP;
                end else begin
                    swa_next   = i_reg;
                    swb_next   = r_reg;
                    ret_next   = RET_PIV;
                    state_next = ST_SW0;
                end
            end
            ST_QS_JCMP: begin
                if ($signed(d_rdata) < $signed(piv_reg)) begin
                    swa_next   = i_reg;
                    swb_next   = j_reg;
                    ret_next   = RET_INC;
                    state_next = ST_SW0;
                end else begin
                    j_next     = j_reg + AW'(1);
                    state_next = ST_QS_JRD;
                end
            end
            ST_RD_RES: begin
                res_next   = d_rdata;
                err_next   = 1'b0;
                state_next = ST_OUT;
            end
            ST_SW0: begin
                d_raddr    = swa_reg;
                state_next = ST_SW1;
            end
            ST_SW1: begin
                tmp_next   = d_rdata;
                d_raddr    = swb_reg;
                state_next = ST_SW2;
            end
            ST_SW2: begin
                d_we       = 1'b1;
                d_waddr    = swa_reg;
                d_wdata    = d_rdata;
                state_next = ST_SW3;
            end
            ST_SW3: begin
                d_we    = 1'b1;
                d_waddr = swb_reg;
                d_wdata = tmp_reg;
                unique case (ret_reg)
                    RET_INC: begin
                        i_next     = i_reg + AW'(1);
                        j_next     = j_reg + AW'(1);
                        state_next = ST_QS_JRD;
                    end
                    RET_PIV: begin
                        m_we    = 1'b1;
                        m_waddr = i_reg;
                        if (s_reg == i_reg) begin
                            res_next   = piv_reg;
                            err_next   = 1'b0;
                            state_next = ST_OUT;
                        end else begin
                            if (s_reg < i_reg) begin
                                r_next = i_reg - AW'(1);
                            end else begin
                                l_next = i_reg + AW'(1);
                            end
                            state_next = ST_QS_TOP;
                        end
                    end
                    RET_PRE1: begin
                        swa_next   = cnt_m1[AW-1:0];
                        swb_next   = (hi_reg == '0) ? lo_reg : hi_reg;
                        ret_next   = RET_PRE2;
                        state_next = ST_SW0;
                    end
                    RET_PRE2: begin
                        m_we       = 1'b1;
                        m_waddr    = '0;
                        state_next = ST_PRE_MARK;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_PRE0: begin
                d_raddr = '0;
                k_next  = CW'(1);
                state_next = (cnt_reg == '0) ? ST_IDLE : ST_PRE1;
            end
            ST_PRE1: begin
                lo_next    = '0;
                hi_next    = '0;
                lov_next   = d_rdata;
                hiv_next   = d_rdata;
                state_next = ST_PRE_ISS;
            end
            ST_PRE_ISS: begin
                d_raddr = k_reg[AW-1:0];
                if (k_reg < cnt_reg) begin
                    state_next = ST_PRE_CMP;
                end else begin
                    swa_next   = '0;
                    swb_next   = lo_reg;
                    ret_next   = RET_PRE1;
                    state_next = ST_SW0;
                end
            end
            ST_PRE_CMP: begin
                if ($signed(d_rdata) < $signed(lov_reg)) begin
                    lo_next  = k_reg[AW-1:0];
                    lov_next = d_rdata;
                end
                if ($signed(hiv_reg) < $signed(d_rdata)) begin
                    hi_next  = k_reg[AW-1:0];
                    hiv_next = d_rdata;
                end
                k_next     = k_reg + CW'(1);
                state_next = ST_PRE_ISS;
            end
            ST_PRE_MARK: begin
                m_we       = 1'b1;
                m_waddr    = cnt_m1[AW-1:0];
                state_next = ST_IDLE;
            end
            ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    ms_next    = res_out;
                    me_next    = err_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

[hdl/orse_ram.sv]
// Single write port, single registered read port memory.
module orse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
